FILE: rtl/core/msi_directory_per_datum_defines.svh
// Assertion macros shared by the directory RTL.
// Users must have i_clk and i_rst_n in scope; no other dependencies.
`ifndef MSI_DIRECTORY_PER_DATUM_DEFINES_SVH
`define MSI_DIRECTORY_PER_DATUM_DEFINES_SVH

// Check a condition in the same cycle.
`define MSIDIR_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (expr)) \
        else $error("msidir same-cycle check failed");

// Check a condition in the next cycle.
`define MSIDIR_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (expr)) \
        else $error("msidir next-cycle check failed");

`endif

FILE: rtl/core/msidir_pkg.sv
// Shared types and constants for the MSI coherence directory.
// No dependencies; used by every module of the block.
package msidir_pkg;

    localparam int NODES        = 8;
    localparam int COUNT_BITS   = 8;
    localparam int NODE_BITS    = 3;
    localparam int MASK_BITS    = 8;
    localparam int KIND_BITS    = 3;
    localparam int MODE_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int CNT_OUT_BITS = 8;
    localparam int STATES_BITS  = 2 * MASK_BITS;
    localparam int PACK_NODES   = (NODES < MASK_BITS) ? NODES : MASK_BITS;
    localparam int PADDR_BITS   = 3;
    localparam int DATA_BITS    = 32;

    localparam logic [PADDR_BITS-3:0] REG_HOME = '0;

    localparam logic [MODE_BITS-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd1;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [1:0] {
        COH_INVALID = 2'd0,
        COH_SHARED  = 2'd1,
        COH_OWNER   = 2'd2
    } t_coh;

    typedef enum logic [KIND_BITS-1:0] {
        K_FETCH    = 3'd0,
        K_RELEASE  = 3'd1,
        K_WTHROUGH = 3'd2,
        K_MODIFIED = 3'd3,
        K_MARKREQ  = 3'd4,
        K_QUERY    = 3'd5
    } t_kind;

    typedef enum logic [STATUS_BITS-1:0] {
        S_HIT    = 3'd0,
        S_MISS   = 3'd1,
        S_NOMEM  = 3'd2,
        S_NOCOPY = 3'd3,
        S_RELINV = 3'd4,
        S_DONE   = 3'd5
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic cfg_wr;
    } t_dp_cmd;

endpackage

FILE: rtl/core/msidir_ctrl.sv
// Request sequencer and output beat control for the directory.
// Depends on msidir_pkg and msi_directory_per_datum_defines.svh.
`include "msi_directory_per_datum_defines.svh"

module msidir_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    output logic                              o_valid,
    input  logic                              i_ready,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [msidir_pkg::PADDR_BITS-1:0] i_paddr,
    output msidir_pkg::t_dp_cmd               o_cmd
);

    msidir_pkg::t_ctrl_state r_state;
    msidir_pkg::t_ctrl_state n_state;
    logic                    r_out_valid;
    logic                    n_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            msidir_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = msidir_pkg::ST_EXEC;
                end
            end
            msidir_pkg::ST_EXEC: begin
                if (!r_out_valid || i_ready) begin
                    n_state = msidir_pkg::ST_IDLE;
                end
            end
            default: n_state = msidir_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready    = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            msidir_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            msidir_pkg::ST_EXEC: begin
                o_cmd.exec = !r_out_valid || i_ready;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
        o_cmd.cfg_wr = i_psel && i_penable && i_pwrite
                       && (i_paddr[msidir_pkg::PADDR_BITS-1:2] == msidir_pkg::REG_HOME);
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= msidir_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

    `MSIDIR_ASSERT_NEXT(a_exec_fills_output, o_cmd.exec, o_valid)
    `MSIDIR_ASSERT_NEXT(a_load_starts_exec, o_cmd.load, r_state == msidir_pkg::ST_EXEC)
    `MSIDIR_ASSERT_NOW(a_exec_when_free, (r_state == msidir_pkg::ST_EXEC) && !r_out_valid,
        o_cmd.exec)

endmodule

FILE: rtl/core/msidir_dp.sv
// Directory datapath: per-node state lanes, request and result registers.
// Depends on msidir_pkg; driven by commands from msidir_ctrl.
module msidir_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  msidir_pkg::t_dp_cmd                i_cmd,
    input  logic [msidir_pkg::KIND_BITS-1:0]   i_kind,
    input  logic [msidir_pkg::NODE_BITS-1:0]   i_node,
    input  logic [msidir_pkg::MODE_BITS-1:0]   i_mode,
    input  logic [msidir_pkg::MASK_BITS-1:0]   i_mask,
    input  logic                               i_copy_ok,
    input  logic [msidir_pkg::DATA_BITS-1:0]   i_pwdata,
    output logic [msidir_pkg::DATA_BITS-1:0]   o_prdata,
    output logic [msidir_pkg::STATUS_BITS-1:0] o_status,
    output logic [msidir_pkg::MASK_BITS-1:0]   o_source_mask,
    output logic                               o_source_read,
    output logic                               o_present,
    output logic [msidir_pkg::CNT_OUT_BITS-1:0] o_ref_count_out,
    output logic [msidir_pkg::STATES_BITS-1:0] o_node_states
);

    localparam int N  = msidir_pkg::NODES;
    localparam int CB = msidir_pkg::COUNT_BITS;

    logic [msidir_pkg::NODE_BITS-1:0]    r_home;
    msidir_pkg::t_coh                    r_coh [N];
    logic [N-1:0]                        r_req;
    logic [CB-1:0]                       r_cnt [N];

    msidir_pkg::t_kind                   r_kind;
    logic [msidir_pkg::NODE_BITS-1:0]    r_node;
    logic [msidir_pkg::MODE_BITS-1:0]    r_mode;
    logic [msidir_pkg::MASK_BITS-1:0]    r_mask;
    logic                                r_copy_ok;

    logic [msidir_pkg::STATUS_BITS-1:0]  r_status;
    logic [msidir_pkg::MASK_BITS-1:0]    r_src;
    logic                                r_sread;
    logic                                r_present;
    logic [msidir_pkg::CNT_OUT_BITS-1:0] r_rc;
    logic [msidir_pkg::STATES_BITS-1:0]  r_packed;

    msidir_pkg::t_coh                    n_coh [N];
    logic [N-1:0]                        n_req;
    logic [CB-1:0]                       n_cnt [N];
    msidir_pkg::t_status                 n_status;
    logic [N-1:0]                        n_src;
    logic                                n_sread;
    logic                                n_present;
    logic [msidir_pkg::STATES_BITS-1:0]  n_packed;

    logic [N-1:0]                        sel;
    logic [N-1:0]                        valid_map;
    logic [N-1:0]                        mask_n;
    logic [N-1:0]                        wt_targets;
    msidir_pkg::t_coh                    local_coh;
    logic [CB-1:0]                       cnt_sel;
    logic [CB-1:0]                       cnt_inc;
    logic [CB-1:0]                       cnt_dec;
    logic [CB-1:0]                       cnt_new;
    logic                                in_range;
    logic                                rd;
    logic                                wr;
    logic                                do_wt;
    logic                                set_req;
    logic                                clr_req;

    always_comb begin
        in_range  = int'(r_node) < N;
        mask_n    = N'(r_mask);
        sel       = '0;
        valid_map = '0;
        local_coh = msidir_pkg::COH_INVALID;
        cnt_sel   = '0;
        for (int i = 0; i < N; i++) begin
            sel[i]       = in_range && (int'(r_node) == i);
            valid_map[i] = r_coh[i] != msidir_pkg::COH_INVALID;
            if (sel[i]) begin
                local_coh = r_coh[i];
                cnt_sel   = r_cnt[i];
            end
            n_coh[i] = r_coh[i];
            n_cnt[i] = r_cnt[i];
        end
        n_req      = r_req;
        rd         = r_mode != msidir_pkg::MODE_WRITE;
        wr         = r_mode != msidir_pkg::MODE_READ;
        cnt_inc    = (cnt_sel == msidir_pkg::CNT_MAX) ? cnt_sel : cnt_sel + CB'(1);
        cnt_dec    = (cnt_sel == '0) ? cnt_sel : cnt_sel - CB'(1);
        cnt_new    = cnt_sel;
        wt_targets = mask_n & ~sel;
        do_wt      = 1'b0;
        set_req    = 1'b0;
        clr_req    = 1'b0;
        n_status   = msidir_pkg::S_DONE;
        n_src      = '0;
        n_sread    = 1'b0;

        if (in_range) begin
            case (r_kind)
                msidir_pkg::K_FETCH: begin
                    if (local_coh == msidir_pkg::COH_OWNER
                        || (local_coh == msidir_pkg::COH_SHARED && !wr)) begin
                        n_status = msidir_pkg::S_HIT;
                        cnt_new  = cnt_inc;
                    end else if (local_coh == msidir_pkg::COH_SHARED) begin
                        for (int i = 0; i < N; i++) begin
                            if (r_coh[i] == msidir_pkg::COH_SHARED) begin
                                n_coh[i] = sel[i] ? msidir_pkg::COH_OWNER
                                                  : msidir_pkg::COH_INVALID;
                            end
                        end
                        n_status = msidir_pkg::S_HIT;
                        cnt_new  = cnt_inc;
                    end else begin
                        n_src = valid_map;
                        if (valid_map == '0) begin
                            n_status = msidir_pkg::S_NOCOPY;
                        end else begin
                            n_sread = rd;
                            if (!r_copy_ok) begin
                                n_status = msidir_pkg::S_NOMEM;
                            end else begin
                                n_status = msidir_pkg::S_MISS;
                                cnt_new  = cnt_inc;
                                clr_req  = 1'b1;
                                for (int i = 0; i < N; i++) begin
                                    if (sel[i]) begin
                                        n_coh[i] = wr ? msidir_pkg::COH_OWNER
                                                      : msidir_pkg::COH_SHARED;
                                    end else if (wr) begin
                                        n_coh[i] = msidir_pkg::COH_INVALID;
                                    end else if (valid_map[i]) begin
                                        n_coh[i] = msidir_pkg::COH_SHARED;
                                    end
                                end
                            end
                        end
                    end
                end
                msidir_pkg::K_RELEASE: begin
                    if (local_coh == msidir_pkg::COH_INVALID) begin
                        n_status = msidir_pkg::S_RELINV;
                    end else begin
                        do_wt   = 1'b1;
                        cnt_new = cnt_dec;
                    end
                end
                msidir_pkg::K_WTHROUGH: begin
                    do_wt = 1'b1;
                end
                msidir_pkg::K_MODIFIED: begin
                    for (int i = 0; i < N; i++) begin
                        n_coh[i] = sel[i] ? msidir_pkg::COH_OWNER : msidir_pkg::COH_INVALID;
                    end
                end
                msidir_pkg::K_MARKREQ: begin
                    set_req = local_coh == msidir_pkg::COH_INVALID;
                end
                default: begin
                    n_status = msidir_pkg::S_DONE;
                end
            endcase
        end

        if (do_wt && (wt_targets != '0)) begin
            n_src   = wt_targets;
            n_sread = 1'b1;
            for (int i = 0; i < N; i++) begin
                if (mask_n[i] || sel[i]) begin
                    n_coh[i] = msidir_pkg::COH_SHARED;
                end
            end
        end

        n_present = 1'b0;
        for (int i = 0; i < N; i++) begin
            if (sel[i]) begin
                n_cnt[i] = cnt_new;
                if (set_req) begin
                    n_req[i] = 1'b1;
                end
                if (clr_req) begin
                    n_req[i] = 1'b0;
                end
                n_present = (n_coh[i] != msidir_pkg::COH_INVALID) || n_req[i];
            end
        end

        n_packed = '0;
        for (int i = 0; i < msidir_pkg::PACK_NODES; i++) begin
            n_packed[2*i +: 2] = n_coh[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home <= '0;
            r_req  <= '0;
            for (int i = 0; i < N; i++) begin
                r_coh[i] <= (i == 0) ? msidir_pkg::COH_OWNER : msidir_pkg::COH_INVALID;
                r_cnt[i] <= '0;
            end
        end else if (i_cmd.cfg_wr) begin
            r_home <= i_pwdata[msidir_pkg::NODE_BITS-1:0];
            for (int i = 0; i < N; i++) begin
                r_coh[i] <= (int'(i_pwdata[msidir_pkg::NODE_BITS-1:0]) == i)
                            ? msidir_pkg::COH_OWNER : msidir_pkg::COH_INVALID;
            end
        end else if (i_cmd.exec) begin
            r_req <= n_req;
            for (int i = 0; i < N; i++) begin
                r_coh[i] <= n_coh[i];
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind    <= msidir_pkg::t_kind'(i_kind);
            r_node    <= i_node;
            r_mode    <= i_mode;
            r_mask    <= i_mask;
            r_copy_ok <= i_copy_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status  <= n_status;
            r_src     <= msidir_pkg::MASK_BITS'(n_src);
            r_sread   <= n_sread;
            r_present <= n_present;
            r_rc      <= msidir_pkg::CNT_OUT_BITS'(cnt_new);
            r_packed  <= n_packed;
        end
    end

    assign o_prdata        = msidir_pkg::DATA_BITS'(r_home);
    assign o_status        = r_status;
    assign o_source_mask   = r_src;
    assign o_source_read   = r_sread;
    assign o_present       = r_present;
    assign o_ref_count_out = r_rc;
    assign o_node_states   = r_packed;

endmodule

FILE: rtl/core/msi_directory_per_datum.sv
// Each request first has its beat registered; then every node lane of the directory
// (state, requested flag, reference count) updates in parallel and the result register
// loads. o_ready stays low until that update is done. A new request is accepted while
// the previous result still waits in the output register; the update cycle holds only
// while that register is full and not being taken. Reset makes node 0 owner and clears
// the rest of the node state, with no clearing pass. Write home_node only while idle.
// Top level of the MSI directory; depends on msidir_pkg, msidir_ctrl and msidir_dp.
module msi_directory_per_datum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [msidir_pkg::KIND_BITS-1:0]    i_kind,
    input  logic [msidir_pkg::NODE_BITS-1:0]    i_node,
    input  logic [msidir_pkg::MODE_BITS-1:0]    i_mode,
    input  logic [msidir_pkg::MASK_BITS-1:0]    i_mask,
    input  logic                                i_copy_ok,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [msidir_pkg::STATUS_BITS-1:0]  o_status,
    output logic [msidir_pkg::MASK_BITS-1:0]    o_source_mask,
    output logic                                o_source_read,
    output logic                                o_present,
    output logic [msidir_pkg::CNT_OUT_BITS-1:0] o_ref_count_out,
    output logic [msidir_pkg::STATES_BITS-1:0]  o_node_states,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msidir_pkg::PADDR_BITS-1:0]   paddr,
    input  logic [msidir_pkg::DATA_BITS-1:0]    pwdata,
    output logic [msidir_pkg::DATA_BITS-1:0]    prdata,
    output logic                                pready
);

    msidir_pkg::t_dp_cmd cmd;

    assign pready = 1'b1;

    msidir_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .o_cmd     (cmd)
    );

    msidir_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_kind          (i_kind),
        .i_node          (i_node),
        .i_mode          (i_mode),
        .i_mask          (i_mask),
        .i_copy_ok       (i_copy_ok),
        .i_pwdata        (pwdata),
        .o_prdata        (prdata),
        .o_status        (o_status),
        .o_source_mask   (o_source_mask),
        .o_source_read   (o_source_read),
        .o_present       (o_present),
        .o_ref_count_out (o_ref_count_out),
        .o_node_states   (o_node_states)
    );

endmodule
